### src/encoder_window_velocity_unit_assert.svh
// ----------------------------------------------------------------------------
// Encoder window velocity assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_WINDOW_VELOCITY_UNIT_ASSERT_SVH
`define ENCODER_WINDOW_VELOCITY_UNIT_ASSERT_SVH

// property must hold at every edge out of reset
`define EWV_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ewv: property violated");

// consequent must hold in the cycle after the antecedent
`define EWV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ewv: sequence violated");

`endif

### src/ewv_pkg.sv
// ----------------------------------------------------------------------------
// ewv_pkg
// Widths, constants and inter-module structs of the encoder window velocity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ewv_pkg;

    // window depth, 2 .. 256
    localparam int WINDOW = 16;
    localparam int SLOT_W = $clog2(WINDOW);

    localparam int ANGLE_W = 14;
    localparam int TIME_W  = 32;
    localparam int ASUM_W  = 22;
    localparam int TSUM_W  = 40;
    localparam int VEL_W   = 48;
    localparam int RING_W  = ANGLE_W + TIME_W;

    localparam int HALF_TURN  = 8192;
    localparam int TURN_COUNT = 16384;

    // largest |angle_sum| over the window
    localparam int MAG_W  = $clog2(HALF_TURN * (WINDOW - 1) + 1);
    // round(8*pi*1e6 * 2^16)
    localparam int K_W    = 41;
    localparam logic [K_W-1:0] VEL_K = 41'd1647099329165;
    localparam int Q_FRAC = 16;
    localparam int PROD_W = MAG_W + K_W;
    localparam int DVD_W  = PROD_W - Q_FRAC;

    localparam logic [VEL_W-1:0] VEL_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_NEG_MAX = 48'h8000_0000_0000;

    // stream packing
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_TUSER_W = 2;
    localparam int LAT_LSB  = 0;
    localparam int ASUM_LSB = LAT_LSB + ANGLE_W;
    localparam int TSUM_LSB = ASUM_LSB + ASUM_W;
    localparam int VEL_LSB  = TSUM_LSB + TSUM_W;
    localparam int OUT_USED = VEL_LSB + VEL_W;
    localparam int USER_VALID = 0;
    localparam int USER_SAT   = 1;

    typedef struct packed {
        logic               wr;
        logic [ANGLE_W-1:0] angle;
        logic [TIME_W-1:0]  stamp;
    } walk_req_t;

    typedef struct packed {
        logic                     done;
        logic [ANGLE_W-1:0]       latest;
        logic signed [ASUM_W-1:0] asum;
        logic [TSUM_W-1:0]        tsum;
    } walk_rsp_t;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;
        logic [TSUM_W-1:0] dvs;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

### src/ewv_ram.sv
// ----------------------------------------------------------------------------
// ewv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ewv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/ewv_walk.sv
// ----------------------------------------------------------------------------
// ewv_walk
// Sample ring: writes the new entry, then walks oldest to newest summing diffs.
// ----------------------------------------------------------------------------
`default_nettype none

module ewv_walk (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ewv_pkg::walk_req_t req,
    output ewv_pkg::walk_rsp_t      rsp
);

    import ewv_pkg::*;

    localparam int DA_W = ANGLE_W + 2;
    localparam logic signed [DA_W-1:0] HALF_S = DA_W'(HALF_TURN);
    localparam logic signed [DA_W-1:0] TURN_S = DA_W'(TURN_COUNT);

    logic [SLOT_W-1:0] ws_reg;
    logic [SLOT_W-1:0] rd_addr_reg;
    logic [SLOT_W-1:0] rd_cnt_reg;
    logic              rd_act_reg;
    logic              rq_vld_reg;
    logic              rq_first_reg;
    logic              rq_last_reg;
    logic              rq_ok_reg;
    logic              done_reg;
    logic [WINDOW-1:0] vld_reg;

    logic [ANGLE_W-1:0]       prv_a_reg;
    logic [TIME_W-1:0]        prv_t_reg;
    logic [ANGLE_W-1:0]       latest_reg;
    logic signed [ASUM_W-1:0] asum_reg;
    logic [TSUM_W-1:0]        tsum_reg;

    logic [RING_W-1:0]        rdata;
    logic [ANGLE_W-1:0]       cur_a;
    logic [TIME_W-1:0]        cur_t;
    logic signed [DA_W-1:0]   da_raw;
    logic signed [DA_W-1:0]   da;
    logic [TIME_W-1:0]        dt;
    logic signed [ASUM_W-1:0] asum_next;
    logic [TSUM_W-1:0]        tsum_next;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(WINDOW - 1)) ? '0 : s + 1'b1;
    endfunction

    ewv_ram #(
        .WIDTH (RING_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (req.wr),
        .waddr (ws_reg),
        .wdata ({req.stamp, req.angle}),
        .re    (rd_act_reg),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    // entries never written read as zero
    always_comb
    begin
        cur_a = rq_ok_reg ? rdata[ANGLE_W-1:0] : '0;
        cur_t = rq_ok_reg ? rdata[RING_W-1:ANGLE_W] : '0;
        da_raw = $signed({2'b00, cur_a}) - $signed({2'b00, prv_a_reg});
        if (da_raw > HALF_S)
        begin
            da = da_raw - TURN_S;
        end
        else if (da_raw < -HALF_S)
        begin
            da = da_raw + TURN_S;
        end
        else
        begin
            da = da_raw;
        end
        dt = cur_t - prv_t_reg;
        asum_next = asum_reg + {{(ASUM_W-DA_W){da[DA_W-1]}}, da};
        tsum_next = tsum_reg + {{(TSUM_W-TIME_W){1'b0}}, dt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg      <= '0;
            rd_addr_reg <= '0;
            rd_cnt_reg  <= '0;
            rd_act_reg  <= 1'b0;
            rq_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            vld_reg     <= '0;
        end
        else
        begin
            if (req.wr)
            begin
                ws_reg          <= slot_inc(ws_reg);
                rd_addr_reg     <= slot_inc(ws_reg);
                rd_cnt_reg      <= '0;
                rd_act_reg      <= 1'b1;
                vld_reg[ws_reg] <= 1'b1;
            end
            else if (rd_act_reg)
            begin
                rd_addr_reg <= slot_inc(rd_addr_reg);
                rd_cnt_reg  <= rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == SLOT_W'(WINDOW - 1))
                begin
                    rd_act_reg <= 1'b0;
                end
            end
            rq_vld_reg <= rd_act_reg;
            done_reg   <= rq_vld_reg && rq_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_first_reg <= (rd_cnt_reg == '0);
        rq_last_reg  <= (rd_cnt_reg == SLOT_W'(WINDOW - 1));
        rq_ok_reg    <= vld_reg[rd_addr_reg];
        if (req.wr)
        begin
            latest_reg <= req.angle;
            asum_reg   <= '0;
            tsum_reg   <= '0;
        end
        if (rq_vld_reg)
        begin
            prv_a_reg <= cur_a;
            prv_t_reg <= cur_t;
            // pairs with no elapsed time are skipped
            if (!rq_first_reg && (dt != '0))
            begin
                asum_reg <= asum_next;
                tsum_reg <= tsum_next;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.latest = latest_reg;
    assign rsp.asum   = asum_reg;
    assign rsp.tsum   = tsum_reg;

endmodule

`default_nettype wire

### src/ewv_vdiv.sv
// ----------------------------------------------------------------------------
// ewv_vdiv
// Velocity quotient: bit-serial multiply by the scale, then restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module ewv_vdiv (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ewv_pkg::div_req_t req,
    output ewv_pkg::div_rsp_t      rsp
);

    import ewv_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_MUL  = 3'b010,
        D_DIV  = 3'b100
    } dstate_t;

    dstate_t           st_reg;
    dstate_t           st_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [MAG_W-1:0]  mpl_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TSUM_W-1:0] dvs_reg;
    logic [TSUM_W-1:0] rem_reg;
    logic [DVD_W-1:0]  dq_reg;

    logic [PROD_W-1:0] prod_next;
    logic [TSUM_W:0]   trial;
    logic              ge;
    logic [TSUM_W:0]   diff;

    always_comb
    begin
        prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                  + (mpl_reg[MAG_W-1] ? {{(PROD_W-K_W){1'b0}}, VEL_K} : '0);
        trial = {rem_reg, dq_reg[DVD_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    st_next = D_MUL;
                end
            end
            D_MUL:
            begin
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    st_next = D_DIV;
                end
            end
            D_DIV:
            begin
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    st_next = D_IDLE;
                end
            end
            default:
            begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == D_DIV) && (st_next == D_IDLE);
            if (st_next != st_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            D_IDLE:
            begin
                mpl_reg  <= req.mag;
                dvs_reg  <= req.dvs;
                prod_reg <= '0;
            end
            D_MUL:
            begin
                prod_reg <= prod_next;
                mpl_reg  <= {mpl_reg[MAG_W-2:0], 1'b0};
                // low Q_FRAC bits of the product drop out of the quotient
                dq_reg   <= prod_next[PROD_W-1:Q_FRAC];
                rem_reg  <= '0;
            end
            D_DIV:
            begin
                rem_reg <= ge ? diff[TSUM_W-1:0] : trial[TSUM_W-1:0];
                dq_reg  <= {dq_reg[DVD_W-2:0], ge};
            end
            default:
            begin
                prod_reg <= '0;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = dq_reg;

endmodule

`default_nettype wire

### src/encoder_window_velocity_unit.sv
// ----------------------------------------------------------------------------
// encoder_window_velocity_unit
// Moving-window encoder velocity estimator with stream input and output.
// ----------------------------------------------------------------------------
// Each request carries an angle sample and its microsecond timestamp; it is
// stored over the oldest ring entry and answered by one result. One request is
// processed at a time: the ring walk reads one entry per cycle through the RAM
// read port, then a bit-serial multiply and a restoring divide form the
// velocity; the multiply and divide are skipped when the time sum is zero, and
// no new request is taken until the result of the last one has gone to the
// output register. A finished result waits in the output register while the
// next request is taken. The ring reads as zero after reset at once; no
// clearing pass is needed.
`default_nettype none

module encoder_window_velocity_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // angle_count, sample_time_us, zero pad
    input  wire logic [ewv_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // latest_angle, angle_sum, time_sum_us, velocity_q16, zero pad
    output logic      [ewv_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // velocity_valid, velocity_saturated
    output logic      [ewv_pkg::OUT_TUSER_W-1:0]   m_tuser
);

    import ewv_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_CALC = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t st_reg;
    state_t st_next;

    walk_req_t walk_req;
    walk_rsp_t walk_rsp;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;
    logic [OUT_TUSER_W-1:0]   m_tuser_reg;
    logic [ANGLE_W-1:0]       res_lat_reg;
    logic signed [ASUM_W-1:0] res_asum_reg;
    logic [TSUM_W-1:0]        res_tsum_reg;
    logic [VEL_W-1:0]         res_vel_reg;
    logic                     res_valid_reg;
    logic                     res_sat_reg;
    logic                     neg_reg;

    logic                     accept;
    logic                     out_free;
    logic                     walk_done;
    logic [ASUM_W-1:0]        asum_abs;
    logic [VEL_W-1:0]         q_ext;
    logic                     sat;
    logic [VEL_W-1:0]         q_clamp;
    logic [VEL_W-1:0]         vel;

    assign s_tready  = (st_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign walk_done = (st_reg == ST_WALK) && walk_rsp.done;

    assign walk_req.wr    = accept;
    assign walk_req.angle = s_tdata[ANGLE_W-1:0];
    assign walk_req.stamp = s_tdata[ANGLE_W+TIME_W-1:ANGLE_W];

    ewv_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (walk_req),
        .rsp   (walk_rsp)
    );

    always_comb
    begin
        asum_abs = walk_rsp.asum[ASUM_W-1] ? (~walk_rsp.asum + ASUM_W'(1))
                                           : walk_rsp.asum;
    end

    assign div_req.start = walk_done && (walk_rsp.tsum != '0);
    assign div_req.mag   = asum_abs[MAG_W-1:0];
    assign div_req.dvs   = walk_rsp.tsum;

    ewv_vdiv u_vdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sign applied after the magnitude divide: truncation toward zero
    always_comb
    begin
        q_ext = {{(VEL_W-DVD_W){1'b0}}, div_rsp.quo};
        if (neg_reg)
        begin
            sat     = (q_ext > VEL_NEG_MAX);
            q_clamp = sat ? VEL_NEG_MAX : q_ext;
            vel     = ~q_clamp + VEL_W'(1);
        end
        else
        begin
            sat     = (q_ext > VEL_POS_MAX);
            q_clamp = sat ? VEL_POS_MAX : q_ext;
            vel     = q_clamp;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    st_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_rsp.done)
                begin
                    st_next = (walk_rsp.tsum != '0) ? ST_CALC : ST_OUT;
                end
            end
            ST_CALC:
            begin
                if (div_rsp.done)
                begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if ((st_reg == ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_done)
        begin
            res_lat_reg   <= walk_rsp.latest;
            res_asum_reg  <= walk_rsp.asum;
            res_tsum_reg  <= walk_rsp.tsum;
            neg_reg       <= walk_rsp.asum[ASUM_W-1];
            res_vel_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_sat_reg   <= 1'b0;
        end
        if ((st_reg == ST_CALC) && div_rsp.done)
        begin
            res_vel_reg   <= vel;
            res_valid_reg <= 1'b1;
            res_sat_reg   <= sat;
        end
        if ((st_reg == ST_OUT) && out_free)
        begin
            m_tdata_reg <= {{(OUT_TDATA_W-OUT_USED){1'b0}}, res_vel_reg, res_tsum_reg,
                            res_asum_reg, res_lat_reg};
            m_tuser_reg <= {res_sat_reg, res_valid_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### src/ewv_checker.sv
// ----------------------------------------------------------------------------
// ewv_checker
// Port-level checks of the encoder window velocity unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_window_velocity_unit_assert.svh"

module ewv_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [ewv_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic [ewv_pkg::OUT_TUSER_W-1:0] m_tuser
);

    import ewv_pkg::*;

    logic [ASUM_W-1:0] o_asum;
    logic [TSUM_W-1:0] o_tsum;
    logic [VEL_W-1:0]  o_vel;
    logic              o_valid;
    logic              o_sat;
    logic              in_req;

    assign o_asum  = m_tdata[TSUM_LSB-1:ASUM_LSB];
    assign o_tsum  = m_tdata[VEL_LSB-1:TSUM_LSB];
    assign o_vel   = m_tdata[OUT_USED-1:VEL_LSB];
    assign o_valid = m_tuser[USER_VALID];
    assign o_sat   = m_tuser[USER_SAT];
    assign in_req  = s_tvalid && s_tready;

    // a stalled result holds
    `EWV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // one request in flight: busy right after a request is taken
    `EWV_ASSERT_NEXT(a_busy_after_req, in_req, !s_tready)
    // valid flag follows a nonzero time sum; invalid results carry no velocity
    `EWV_ASSERT_HOLDS(a_valid_tsum, m_tvalid |-> (o_valid == (o_tsum != '0)))
    `EWV_ASSERT_HOLDS(a_invalid_zero, (m_tvalid && !o_valid) |-> (o_vel == '0 && !o_sat))
    // no angle movement, no velocity
    `EWV_ASSERT_HOLDS(a_still_zero, (m_tvalid && o_asum == '0) |-> (o_vel == '0))

endmodule

bind encoder_window_velocity_unit ewv_checker u_ewv_checker (.*);

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: encoder window velocity unit
// Streams angle/timestamp requests into the unit and checks every result
// against a window predictor kept in step with each accepted request, or
// against literal values for the first sweep rows. A short sweep covers
// half-turn edges, timestamp wrap and repeated stamps. Random motion segments
// follow under three idle patterns and one long output stall.
// ----------------------------------------------------------------------------

module tb;

    import ewv_pkg::*;

    typedef struct {
        logic [ANGLE_W-1:0]       latest;
        logic signed [ASUM_W-1:0] asum;
        logic [TSUM_W-1:0]        tsum;
        logic [VEL_W-1:0]         vel;
        logic                     valid;
        logic                     sat;
    } vel_result_t;

    typedef struct {
        logic [ANGLE_W-1:0] ang;
        logic [TIME_W-1:0]  stamp;
        bit                 typed;
        vel_result_t        want;
    } sweep_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    // predictor copy of the sample window
    logic [ANGLE_W-1:0] ang_hist [WINDOW];
    logic [TIME_W-1:0]  stamp_hist [WINDOW];
    int unsigned        next_slot;

    vel_result_t  pending_results [$];
    sweep_row_t   sweep_rows [$];
    vel_result_t  no_literal;

    logic [ANGLE_W-1:0] last_ang;
    logic [TIME_W-1:0]  last_stamp;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_go;
    int n_sent;
    int n_checked;
    int n_no_span;
    int n_errors;

    encoder_window_velocity_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(20_000_000);
        $display("tb: timeout, %0d results still pending", pending_results.size());
        $display("tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (n_errors < 40)
            $display("tb: MISMATCH %s got %h want %h (result %0d)", what, got, want,
                     n_checked);
        n_errors++;
    endtask

    // writes the sample over the oldest entry, then sums the window oldest to newest
    function automatic vel_result_t predict_velocity(input logic [ANGLE_W-1:0] ang,
                                                     input logic [TIME_W-1:0] stamp);
        vel_result_t       r;
        int unsigned       cur;
        int unsigned       prv;
        int                da;
        int                asum_acc;
        logic [TIME_W-1:0] dt;
        longint unsigned   tsum_acc;
        longint unsigned   mag;
        longint unsigned   q;
        longint unsigned   q_neg;
        longint unsigned   pos_lim;
        longint unsigned   neg_lim;

        ang_hist[next_slot] = ang;
        stamp_hist[next_slot] = stamp;
        next_slot = (next_slot + 1) % WINDOW;
        asum_acc = 0;
        tsum_acc = 0;
        for (int k = 1; k < WINDOW; k++)
        begin
            cur = (next_slot + k) % WINDOW;
            prv = (cur == 0) ? WINDOW - 1 : cur - 1;
            da = int'(ang_hist[cur]) - int'(ang_hist[prv]);
            dt = stamp_hist[cur] - stamp_hist[prv];
            // exactly half a turn stays as is
            if (da > HALF_TURN)
                da -= TURN_COUNT;
            else if (da < -HALF_TURN)
                da += TURN_COUNT;
            if (dt != '0)
            begin
                asum_acc += da;
                tsum_acc += dt;
            end
        end

        r.latest = ang;
        r.asum = asum_acc[ASUM_W-1:0];
        r.tsum = tsum_acc[TSUM_W-1:0];
        r.vel = '0;
        r.valid = 1'b0;
        r.sat = 1'b0;
        if (tsum_acc != 0)
        begin
            pos_lim = VEL_POS_MAX;
            neg_lim = VEL_NEG_MAX;
            mag = (asum_acc < 0) ? longint'(-asum_acc) : longint'(asum_acc);
            q = (mag * VEL_K) / (tsum_acc << Q_FRAC);
            r.valid = 1'b1;
            if (asum_acc < 0)
            begin
                if (q > neg_lim)
                begin
                    q = neg_lim;
                    r.sat = 1'b1;
                end
                q_neg = 64'd0 - q;
                r.vel = q_neg[VEL_W-1:0];
            end
            else
            begin
                if (q > pos_lim)
                begin
                    q = pos_lim;
                    r.sat = 1'b1;
                end
                r.vel = q[VEL_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void add_row(input logic [ANGLE_W-1:0] a, input logic [TIME_W-1:0] t);
        sweep_row_t row;
        row.ang = a;
        row.stamp = t;
        row.typed = 1'b0;
        sweep_rows.push_back(row);
    endfunction

    function automatic void add_checked_row(input logic [ANGLE_W-1:0] a,
                                            input logic [TIME_W-1:0] t,
                                            input vel_result_t want);
        sweep_row_t row;
        row.ang = a;
        row.stamp = t;
        row.typed = 1'b1;
        row.want = want;
        sweep_rows.push_back(row);
    endfunction

    // one request; the expectation is queued once the unit takes it
    task automatic offer_sample(input logic [ANGLE_W-1:0] a, input logic [TIME_W-1:0] t,
                                input bit typed, input vel_result_t want);
        vel_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - ANGLE_W - TIME_W){1'b0}}, t, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_velocity(a, t);
        pending_results.push_back(typed ? want : predicted);
        last_ang = a;
        last_stamp = t;
        n_sent++;
    endtask

    // random motion: mostly steady segments, some noise, some stuck timestamps
    task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct);
        int                 sent;
        int                 seg_len;
        int                 kind;
        int                 rate;
        int unsigned        span;
        logic [ANGLE_W-1:0] a;
        logic [TIME_W-1:0]  t;

        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            seg_len = $urandom_range(4, 40);
            kind = $urandom_range(0, 99);
            rate = int'($urandom_range(0, TURN_COUNT - 1)) - HALF_TURN;
            if ($urandom_range(0, 2) != 0)
                rate = rate / 128;
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50000)
                                               : $urandom_range(1, 64);
            // push the stamp up against the 32-bit wrap
            if ($urandom_range(0, 7) == 0)
                last_stamp = 32'hFFFF_FFFF - $urandom_range(0, span * 8);
            for (int j = 0; j < seg_len && sent < n_items; j++)
            begin
                if (kind < 75)
                begin
                    a = ANGLE_W'(last_ang + rate + int'($urandom_range(0, 6)) - 3);
                    t = ($urandom_range(0, 19) == 0) ? last_stamp
                        : last_stamp + span + $urandom_range(0, span / 8);
                end
                else if (kind < 90)
                begin
                    a = ANGLE_W'($urandom);
                    t = $urandom;
                end
                else
                begin
                    a = ANGLE_W'($urandom);
                    t = last_stamp;
                end
                offer_sample(a, t, 1'b0, no_literal);
                sent++;
            end
        end
    endtask

    always @(negedge clk)
    begin : output_pacing
        int hold_seen;
        int hold_left;
        if (hold_go != hold_seen)
        begin
            hold_seen = hold_go;
            hold_left = 1500;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        vel_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[LAT_LSB +: ANGLE_W] !== want.latest)
                    report_mismatch("latest_angle", 64'(m_tdata[LAT_LSB +: ANGLE_W]),
                                    64'(want.latest));
                if (m_tdata[ASUM_LSB +: ASUM_W] !== want.asum)
                    report_mismatch("angle_sum", 64'(m_tdata[ASUM_LSB +: ASUM_W]),
                                    {{(64-ASUM_W){1'b0}}, want.asum});
                if (m_tdata[TSUM_LSB +: TSUM_W] !== want.tsum)
                    report_mismatch("time_sum_us", 64'(m_tdata[TSUM_LSB +: TSUM_W]),
                                    64'(want.tsum));
                if (m_tdata[VEL_LSB +: VEL_W] !== want.vel)
                    report_mismatch("velocity_q16", 64'(m_tdata[VEL_LSB +: VEL_W]),
                                    64'(want.vel));
                if (m_tuser[USER_VALID] !== want.valid)
                    report_mismatch("velocity_valid", 64'(m_tuser[USER_VALID]),
                                    64'(want.valid));
                if (m_tuser[USER_SAT] !== want.sat)
                    report_mismatch("velocity_saturated", 64'(m_tuser[USER_SAT]),
                                    64'(want.sat));
                if (m_tdata[OUT_TDATA_W-1:OUT_USED] !== '0)
                    report_mismatch("tdata pad", 64'(m_tdata[OUT_TDATA_W-1:OUT_USED]), 64'd0);
                if (!want.valid)
                    n_no_span++;
                n_checked++;
            end
        end
    end

    initial
    begin
        logic [ANGLE_W-1:0] a;
        logic [TIME_W-1:0]  t;

        for (int k = 0; k < WINDOW; k++)
        begin
            ang_hist[k] = '0;
            stamp_hist[k] = '0;
        end
        next_slot = 0;
        last_ang = '0;
        last_stamp = '0;
        tx_idle_pct = 13;
        rx_idle_pct = 83;
        hold_go = 0;
        n_sent = 0;
        n_checked = 0;
        n_no_span = 0;
        n_errors = 0;

        // cleared window: nothing moves, no time span
        add_checked_row(14'd0, 32'd0, '{14'd0, 22'sd0, 40'd0, 48'd0, 1'b0, 1'b0});
        // one step back across zero with the largest stamp
        add_checked_row(14'd16383, 32'hFFFF_FFFF,
                        '{14'd16383, -22'sd1, 40'h00_FFFF_FFFF, 48'd0, 1'b1, 1'b0});
        add_row(14'd8191, 32'd0);       // stamp wraps, minus half a turn kept
        add_row(14'd0, 32'd0);          // repeated stamp, pair skipped
        add_row(14'd8192, 32'd100);     // plus half a turn kept
        add_row(14'd0, 32'd100);
        add_row(14'd8193, 32'd200);     // just past half a turn, wraps
        add_row(14'd0, 32'd300);
        a = 14'd0;
        t = 32'd300;
        // fastest forward spin: just under half a turn per microsecond
        for (int k = 0; k < 15; k++)
        begin
            a = a + 14'd8191;
            t = t + 32'd1;
            add_row(a, t);
        end
        for (int k = 0; k < 2; k++)
        begin
            a = a - 14'd8191;
            t = t + 32'd1;
            add_row(a, t);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (sweep_rows[k])
            offer_sample(sweep_rows[k].ang, sweep_rows[k].stamp, sweep_rows[k].typed,
                         sweep_rows[k].want);

        run_phase(610, 13, 83);
        run_phase(610, 83, 13);
        hold_go++;
        run_phase(610, 0, 0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("tb: %0d requests, %0d results checked, %0d with no time span",
                 n_sent, n_checked, n_no_span);
        $display("tb: half-turn edges, stamp wrap, repeated stamps, noise, long output stall");
        if (n_errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
